### rtl/etps_pkg.sv
// Shared constants, codes and controller/datapath interface types for the edge trace sequencer.
package etps_pkg;

   localparam int MAX_WIDTH  = 320;
   localparam int MAX_HEIGHT = 240;
   localparam int REACH      = 2;
   localparam int SPAN       = 2 * REACH + 1;
   localparam int ROW_W      = 8;
   localparam int COL_W      = 9;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int NBR_W      = $clog2(SPAN + 1);
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      CMD_UP   = 2'd0,
      CMD_DOWN = 2'd1,
      CMD_HOME = 2'd2
   } cmd_type;

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_SCAN     = 3'd1,
      PH_SEARCH   = 3'd2,
      PH_FOUND    = 3'd3,
      PH_UP_EXTRA = 3'd4,
      PH_DOWN     = 3'd5,
      PH_UP_LAST  = 3'd6,
      PH_DONE     = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE     = 3'd0,
      CS_DISPATCH = 3'd1,
      CS_SCAN_CHK = 3'd2,
      CS_NBR_CHK  = 3'd3,
      CS_EMIT     = 3'd4
   } ctl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic    write_pixel;
      logic    scan_reset;
      logic    scan_next_row;
      logic    scan_read;
      logic    take_scan;
      logic    scan_advance;
      logic    nbr_read;
      logic    take_nbr;
      logic    clear_nbr;
      logic    nbr_advance;
      logic    nbr_restart;
      logic    emit_load;
      cmd_type kind;
      logic    done;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       col_end;
      logic       row_end;
      logic       pixel;
      logic       nbr_end;
      logic       nbr_row_last;
      logic [1:0] step;
      logic       out_free;
   } dp_sts_type;

endpackage

### rtl/etps_ram.sv
// Generic simple dual-port RAM with registered read.
module etps_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/etps_ctrl.sv
// Trace controller: cycle sequencing and the trace phase register.
module etps_ctrl import etps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_op,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   cmd_type       kind_ff, kind_in;
   logic          done_ff, done_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         phase_ff <= PH_START;
         kind_ff  <= CMD_HOME;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         done_ff  <= done_in;
      end
   end

   // next state and commands
   always_comb begin
      phase_type ph_nbr;
      state_in   = state_ff;
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      done_in    = done_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.kind   = kind_ff;
      cmd.done   = done_ff;
      ph_nbr     = phase_ff;
      unique case (state_ff)
         CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (op_type'(req_op) == OP_WRITE) begin
                  cmd.write_pixel = 1'b1;
                  if (phase_ff == PH_DONE) begin
                     phase_in = PH_START;
                  end
               end else begin
                  state_in = CS_DISPATCH;
               end
            end
         end
         CS_DISPATCH: begin
            unique case (phase_ff)
               PH_START: begin
                  cmd.scan_reset = 1'b1;
                  phase_in = PH_SCAN;
                  kind_in  = CMD_HOME;
                  done_in  = 1'b0;
                  state_in = CS_EMIT;
               end
               PH_SCAN: begin
                  if (sts.col_end) begin
                     cmd.scan_next_row = 1'b1;
                  end else if (sts.row_end) begin
                     phase_in = PH_DONE;
                     kind_in  = CMD_HOME;
                     done_in  = 1'b1;
                     state_in = CS_EMIT;
                  end else begin
                     cmd.scan_read = 1'b1;
                     state_in = CS_SCAN_CHK;
                  end
               end
               PH_SEARCH, PH_FOUND: begin
                  if (sts.nbr_end) begin
                     phase_in = PH_SCAN;
                     kind_in  = CMD_UP;
                     done_in  = 1'b0;
                     state_in = CS_EMIT;
                  end else begin
                     cmd.nbr_read = 1'b1;
                     state_in = CS_NBR_CHK;
                  end
               end
               PH_UP_EXTRA: begin
                  phase_in = PH_DOWN;
                  kind_in  = CMD_UP;
                  done_in  = 1'b0;
                  state_in = CS_EMIT;
               end
               PH_DOWN: begin
                  phase_in = PH_UP_LAST;
                  kind_in  = CMD_DOWN;
                  done_in  = 1'b0;
                  state_in = CS_EMIT;
               end
               PH_UP_LAST: begin
                  cmd.nbr_restart = 1'b1;
                  phase_in = PH_SEARCH;
                  kind_in  = CMD_UP;
                  done_in  = 1'b0;
                  state_in = CS_EMIT;
               end
               default: begin
                  kind_in  = CMD_HOME;
                  done_in  = 1'b1;
                  state_in = CS_EMIT;
               end
            endcase
         end
         CS_SCAN_CHK: begin
            cmd.scan_advance = 1'b1;
            if (sts.pixel) begin
               cmd.take_scan = 1'b1;
               phase_in = PH_SEARCH;
            end
            state_in = CS_DISPATCH;
         end
         CS_NBR_CHK: begin
            if (sts.pixel && sts.step >= 2'd2) begin
               // third step on: stroke at the new centre
               cmd.take_nbr  = 1'b1;
               cmd.clear_nbr = 1'b1;
               phase_in = (sts.step == 2'd2) ? PH_UP_EXTRA : PH_DOWN;
               kind_in  = CMD_UP;
               done_in  = 1'b0;
               state_in = CS_EMIT;
            end else begin
               if (sts.pixel) begin
                  cmd.take_nbr = 1'b1;
                  ph_nbr = PH_FOUND;
               end
               if (ph_nbr == PH_FOUND && sts.nbr_row_last) begin
                  cmd.nbr_restart = 1'b1;
                  phase_in = PH_SEARCH;
               end else begin
                  cmd.nbr_advance = 1'b1;
                  phase_in = ph_nbr;
               end
               state_in = CS_DISPATCH;
            end
         end
         CS_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

### rtl/etps_datapath.sv
// Trace datapath: config registers, edge map, scan and neighbor counters, output register.
module etps_datapath import etps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [0:0]            csr_index,
   input  logic [COL_W-1:0]      csr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts
);

   logic [COL_W-1:0] width_ff;
   logic [ROW_W-1:0] height_ff;
   logic [COL_W-1:0] w_act;
   logic [ROW_W-1:0] h_act;

   logic [ROW_W-1:0] scan_row_ff, centre_row_ff, tgt_row_ff, tgt_row;
   logic [COL_W-1:0] scan_col_ff, centre_col_ff, tgt_col_ff, tgt_col;
   logic [1:0]       step_ff;
   logic [NBR_W-1:0] nbr_r_ff, nbr_c_ff;

   logic             out_valid_ff;
   cmd_type          out_kind_ff;
   logic             out_done_ff;
   logic [COL_W-1:0] out_x_ff;
   logic [ROW_W-1:0] out_y_ff;

   logic [ROW_W-1:0] in_row;
   logic [COL_W-1:0] in_col;
   logic             in_edge;

   logic              ram_we, ram_re, ram_rdata;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic              ram_wdata;

   logic signed [ROW_W+1:0] row_sum, row_hi;
   logic signed [COL_W+1:0] col_sum, col_hi;

   assign in_row  = req_tdata[ROW_W-1:0];
   assign in_col  = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign in_edge = req_tdata[ROW_W+COL_W];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= COL_W'(MAX_WIDTH);
         height_ff <= ROW_W'(MAX_HEIGHT);
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data[ROW_W-1:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // active size, out-of-range values limited
   always_comb begin
      if (width_ff == '0) begin
         w_act = COL_W'(1);
      end else if (width_ff > COL_W'(MAX_WIDTH)) begin
         w_act = COL_W'(MAX_WIDTH);
      end else begin
         w_act = width_ff;
      end
      if (height_ff == '0) begin
         h_act = ROW_W'(1);
      end else if (height_ff > ROW_W'(MAX_HEIGHT)) begin
         h_act = ROW_W'(MAX_HEIGHT);
      end else begin
         h_act = height_ff;
      end
   end

   // clamped neighbor position
   always_comb begin
      row_sum = $signed({2'b00, centre_row_ff})
              + $signed((ROW_W+2)'(nbr_r_ff)) - $signed((ROW_W+2)'(REACH));
      row_hi  = $signed({2'b00, h_act}) - $signed((ROW_W+2)'(1));
      col_sum = $signed({2'b00, centre_col_ff})
              + $signed((COL_W+2)'(nbr_c_ff)) - $signed((COL_W+2)'(REACH));
      col_hi  = $signed({2'b00, w_act}) - $signed((COL_W+2)'(1));
      if (row_sum < 0) begin
         tgt_row = '0;
      end else if (row_sum > row_hi) begin
         tgt_row = row_hi[ROW_W-1:0];
      end else begin
         tgt_row = row_sum[ROW_W-1:0];
      end
      if (col_sum < 0) begin
         tgt_col = '0;
      end else if (col_sum > col_hi) begin
         tgt_col = col_hi[COL_W-1:0];
      end else begin
         tgt_col = col_sum[COL_W-1:0];
      end
   end

   // edge map ports
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(scan_row_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(scan_col_ff);
      ram_wdata = 1'b0;
      if (cmd.write_pixel) begin
         ram_we    = (in_row < ROW_W'(MAX_HEIGHT)) && (in_col < COL_W'(MAX_WIDTH));
         ram_waddr = ADDR_W'(in_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
         ram_wdata = in_edge;
      end else if (cmd.clear_nbr) begin
         ram_we    = 1'b1;
         ram_waddr = ADDR_W'(tgt_row_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tgt_col_ff);
      end else if (cmd.take_scan) begin
         ram_we    = 1'b1;
      end
      ram_re = cmd.scan_read | cmd.nbr_read;
      if (cmd.nbr_read) begin
         ram_raddr = ADDR_W'(tgt_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tgt_col);
      end else begin
         ram_raddr = ADDR_W'(scan_row_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(scan_col_ff);
      end
   end

   etps_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // scan, centre and neighbor counters
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         centre_row_ff <= '0;
         centre_col_ff <= '0;
         step_ff       <= '0;
         nbr_r_ff      <= '0;
         nbr_c_ff      <= '0;
      end else begin
         if (cmd.scan_reset) begin
            scan_row_ff <= '0;
            scan_col_ff <= '0;
         end else if (cmd.scan_next_row) begin
            scan_row_ff <= scan_row_ff + ROW_W'(1);
            scan_col_ff <= '0;
         end else if (cmd.scan_advance) begin
            scan_col_ff <= scan_col_ff + COL_W'(1);
         end
         if (cmd.take_scan) begin
            centre_row_ff <= scan_row_ff;
            centre_col_ff <= scan_col_ff;
            step_ff       <= 2'd1;
         end else if (cmd.take_nbr) begin
            centre_row_ff <= tgt_row_ff;
            centre_col_ff <= tgt_col_ff;
            step_ff       <= (step_ff == 2'd3) ? 2'd3 : step_ff + 2'd1;
         end
         if (cmd.take_scan || cmd.nbr_restart) begin
            nbr_r_ff <= '0;
            nbr_c_ff <= '0;
         end else if (cmd.nbr_advance) begin
            if (nbr_c_ff == NBR_W'(SPAN - 1)) begin
               nbr_c_ff <= '0;
               nbr_r_ff <= nbr_r_ff + NBR_W'(1);
            end else begin
               nbr_c_ff <= nbr_c_ff + NBR_W'(1);
            end
         end
      end
   end

   // latched neighbor position for the check cycle
   always_ff @(posedge clock) begin
      if (cmd.nbr_read) begin
         tgt_row_ff <= tgt_row;
         tgt_col_ff <= tgt_col;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_kind_ff <= cmd.kind;
         out_done_ff <= cmd.done;
         if (cmd.kind == CMD_HOME) begin
            out_x_ff <= '0;
            out_y_ff <= '0;
         end else begin
            out_x_ff <= centre_col_ff - (w_act >> 1);
            out_y_ff <= centre_row_ff - (h_act >> 1);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-COL_W-ROW_W-1){1'b0}}, out_done_ff, out_y_ff, out_x_ff};

   // status
   assign sts.col_end      = scan_col_ff >= w_act;
   assign sts.row_end      = scan_row_ff >= h_act;
   assign sts.pixel        = ram_rdata;
   assign sts.nbr_end      = nbr_r_ff >= NBR_W'(SPAN);
   assign sts.nbr_row_last = nbr_c_ff == NBR_W'(SPAN - 1);
   assign sts.step         = step_ff;
   assign sts.out_free     = !out_valid_ff || rsp_tready;

endmodule

### rtl/edge_trace_plot_sequencer_top.sv
// Top level of the edge trace plot sequencer: controller plus datapath.
// A pixel write is taken while idle and gives no result.
// A command request steps through dispatch and a check state for each raster pixel or neighbor
// probed, each with a read on the single read port of the edge map RAM, then waits in the emit
// state until the output register is free (rsp_tready); only one request is in progress at a time.
// Synchronous active-high reset clears control, counters and the output register and
// loads width 320, height 240; the edge map is not cleared and needs no clearing pass.
module edge_trace_plot_sequencer_top import etps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pixel_row, pixel_col, edge_on, zero pad
   input  logic                  req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // x_offset, y_offset, trace_done, zero pad
   output logic [1:0]            rsp_tuser,  // command_kind
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [COL_W-1:0]      csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // config writes always taken
   assign csr_ready = 1'b1;

   etps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   etps_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
